// ===== hdl/csct_pkg.sv =====
// ----------------------------------------------------------------------------
// csct_pkg: shared types and constants of the counter-mode cipher with tag
// Lane types, sequencer states and the round constants of the permutation.
// ----------------------------------------------------------------------------
`default_nettype none

package csct_pkg;

  localparam int ROUND_COUNT = 20;
  localparam int KEY_COUNT   = ROUND_COUNT + 2;
  localparam int RK_AW       = $clog2(KEY_COUNT);

  localparam logic [31:0] MUL_K = 32'h9E37_79B9;
  localparam logic [31:0] ADD_K = 32'hBB67_AE85;

  // Initial state of the key schedule.
  localparam logic [7:0][31:0] EXP_INIT = {
    32'h5BE0_CD19, 32'h1F83_D9AB, 32'h9B05_688C, 32'h510E_527F,
    32'hA54F_F53A, 32'h3C6E_F372, 32'hBB67_AE85, 32'h6A09_E667
  };

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_IV_LOW  = 3'd4;
  localparam logic [2:0] REG_IV_HIGH = 3'd5;

  // Eight 32-bit lanes; lane 2i is the low half of word i.
  typedef logic [7:0][31:0] lanes_t;

  typedef enum logic [2:0] {
    S_EXP_INIT,
    S_EXPAND,
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_ABSORB,
    S_TAG,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/ctr_stream_cipher_with_tag.sv =====
// ----------------------------------------------------------------------------
// ctr_stream_cipher_with_tag: counter-mode stream cipher with 128-bit tag
// Encrypts or decrypts 32-byte beats and folds the ciphertext into a tag.
// ----------------------------------------------------------------------------
// One input beat is one 32-byte block. The block runs one block at a time on
// a single eight-lane multiply-add unit under a small sequencer: one
// permutation round per cycle. From acceptance to the result beat a non-last
// block passes through 20 rounds, the keystream XOR, the accumulator step
// and the output load, and a last block also runs the tag finalization
// rounds. A write to any key register, and reset, start a key expansion
// (one round key per cycle through the same unit) during which in_ready is
// low; configuration writes are always taken. The result beat sits in an
// output register, so the next block is accepted while the previous result
// still waits.
`default_nettype none

module ctr_stream_cipher_with_tag
  import csct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // input block channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [63:0] in_data_word0,
  input  wire logic [63:0] in_data_word1,
  input  wire logic [63:0] in_data_word2,
  input  wire logic [63:0] in_data_word3,
  input  wire logic [5:0]  in_byte_count,
  input  wire logic        in_last_block,
  input  wire logic [63:0] in_recv_tag_low,
  input  wire logic [63:0] in_recv_tag_high,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_word0,
  output logic [63:0]      out_word1,
  output logic [63:0]      out_word2,
  output logic [63:0]      out_word3,
  output logic [5:0]       out_count,
  output logic             out_last,
  output logic [63:0]      out_tag_low,
  output logic [63:0]      out_tag_high,
  output logic             out_tag_match
);

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Swap adjacent lanes within each 128-bit half.
  function automatic lanes_t swap_pairs(input lanes_t s);
    lanes_t d;
    for (int h = 0; h < 8; h += 4) begin
      d[h] = s[h+1]; d[h+1] = s[h]; d[h+2] = s[h+3]; d[h+3] = s[h+2];
    end
    return d;
  endfunction

  // Lane order 3,2,0,1 within each 128-bit half.
  function automatic lanes_t mix_order(input lanes_t s);
    lanes_t d;
    for (int h = 0; h < 8; h += 4) begin
      d[h] = s[h+3]; d[h+1] = s[h+2]; d[h+2] = s[h]; d[h+3] = s[h+1];
    end
    return d;
  endfunction

  // Configuration registers.
  logic [255:0] key_r;
  logic [63:0]  iv_low_r;
  logic [63:0]  iv_high_r;
  logic         key_write;

  // Sequencer.
  state_t           state_r, state_nxt;
  logic [RK_AW-1:0] step_r;
  logic [1:0]       tag_idx_r;

  // Round key memory, one 256-bit round key per entry, registered read.
  lanes_t           rk_mem [KEY_COUNT];
  lanes_t           rk_q;
  logic [RK_AW-1:0] rd_addr;

  // Datapath.
  lanes_t       st_r;
  lanes_t       k_r;
  lanes_t       acc_r;
  logic [255:0] data_r;
  logic         mode_r;
  logic [5:0]   cnt_r;
  logic         last_r;
  logic [127:0] recv_tag_r;
  logic [63:0]  blk_r;
  logic         in_message_r;

  // Result register.
  logic         out_valid_r;
  logic [255:0] out_data_r;
  logic [5:0]   out_count_r;
  logic         out_last_r;
  logic [127:0] out_tag_r;
  logic         out_match_r;

  // Shared multiply-add unit: prod = a * MUL_K + b in every lane.
  lanes_t mul_a, mul_b, prod;
  lanes_t exp_st, rnd_st, prod_sw;
  logic [255:0] byte_mask, ks, din_m, res_m, absorbed;
  logic [63:0]  blk_use, ctr1, ctr2;
  logic [5:0]   cnt_clamp;
  logic [127:0] tag_calc;
  logic         accept;

  assign accept    = in_valid && in_ready;
  assign key_write = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

  always_comb begin
    mul_a = st_r;
    mul_b = rk_q;
    unique case (state_r)
      S_EXPAND: begin
        mul_b = k_r;
      end
      S_ABSORB: begin
        mul_a = acc_r;
        for (int j = 0; j < 8; j++) mul_b[j] = ADD_K;
      end
      S_TAG: begin
        for (int j = 0; j < 8; j++) begin
          mul_a[j] = acc_r[j] + rk_q[j];
          mul_b[j] = '0;
        end
      end
      default: begin
      end
    endcase
    for (int j = 0; j < 8; j++) prod[j] = mul_a[j] * MUL_K + mul_b[j];
  end

  always_comb begin
    lanes_t perm, mixed;
    perm    = swap_pairs(prod);
    mixed   = mix_order(prod);
    prod_sw = perm;
    for (int j = 0; j < 8; j++) begin
      exp_st[j] = rotl(st_r[j] ^ perm[j], 7);
      rnd_st[j] = (mixed[j] ^ rotl(mixed[j], 13)) + ADD_K;
    end
  end

  // Keystream finish, byte masking and the absorbed ciphertext.
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      byte_mask[8*b +: 8] = (6'(b) < cnt_r) ? 8'hFF : 8'h00;
    end
    ks       = st_r ^ rk_q;
    din_m    = data_r & byte_mask;
    res_m    = (data_r ^ ks) & byte_mask;
    absorbed = mode_r ? din_m : res_m;
  end

  assign cnt_clamp = (in_byte_count > 6'd32) ? 6'd32 : in_byte_count;
  assign blk_use   = in_message_r ? blk_r : 64'd0;
  assign ctr1      = iv_low_r + {blk_use[62:0], 1'b0};
  assign ctr2      = ctr1 + 64'd1;
  assign tag_calc  = {acc_r[3] ^ acc_r[7], acc_r[2] ^ acc_r[6],
                      acc_r[1] ^ acc_r[5], acc_r[0] ^ acc_r[4]};

  // Next state and memory read address.
  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_EXP_INIT: state_nxt = S_EXPAND;
      S_EXPAND: begin
        if (step_r == RK_AW'(KEY_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        rd_addr = step_r + RK_AW'(1);
        if (step_r == RK_AW'(ROUND_COUNT - 1)) state_nxt = S_FINAL;
      end
      S_FINAL:  state_nxt = S_ABSORB;
      S_ABSORB: state_nxt = last_r ? S_TAG : S_DONE;
      S_TAG: begin
        rd_addr = RK_AW'(tag_idx_r) + RK_AW'(1);
        if (tag_idx_r == 2'd3) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_EXP_INIT;
    endcase
    // A key write restarts the schedule from the new key.
    if (key_write) state_nxt = S_EXP_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_EXP_INIT;
    else        state_r <= state_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      iv_low_r  <= '0;
      iv_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:    key_r[63:0]    <= cfg_data;
        REG_KEY1:    key_r[127:64]  <= cfg_data;
        REG_KEY2:    key_r[191:128] <= cfg_data;
        REG_KEY3:    key_r[255:192] <= cfg_data;
        REG_IV_LOW:  iv_low_r       <= cfg_data;
        REG_IV_HIGH: iv_high_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Round key memory.
  always_ff @(posedge clk) begin
    if (state_r == S_EXPAND) rk_mem[step_r] <= exp_st;
    rk_q <= rk_mem[rd_addr];
  end

  // Message control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r <= 1'b0;
      blk_r        <= '0;
      step_r       <= '0;
      tag_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_EXP_INIT: step_r <= '0;
        S_EXPAND:   step_r <= step_r + RK_AW'(1);
        S_IDLE: begin
          step_r <= '0;
          if (accept) begin
            in_message_r <= 1'b1;
            blk_r        <= blk_use;
          end
        end
        S_ROUND:  step_r <= step_r + RK_AW'(1);
        S_FINAL:  blk_r  <= blk_r + 64'd1;
        S_ABSORB: tag_idx_r <= '0;
        S_TAG:    tag_idx_r <= tag_idx_r + 2'd1;
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (last_r) in_message_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_EXP_INIT: begin
        st_r <= EXP_INIT;
        k_r  <= key_r;
      end
      S_EXPAND: begin
        st_r <= exp_st;
        for (int j = 0; j < 8; j++) k_r[j] <= k_r[j] + ADD_K;
      end
      S_IDLE: begin
        if (accept) begin
          mode_r     <= in_mode;
          data_r     <= {in_data_word3, in_data_word2, in_data_word1, in_data_word0};
          cnt_r      <= cnt_clamp;
          last_r     <= in_last_block;
          recv_tag_r <= {in_recv_tag_high, in_recv_tag_low};
          st_r       <= {ctr2[31:0], ctr2[63:32], iv_high_r[31:0], iv_high_r[63:32],
                         ctr1[31:0], ctr1[63:32], iv_high_r[31:0], iv_high_r[63:32]};
          if (!in_message_r) acc_r <= {128'd0, iv_high_r, iv_low_r};
        end
      end
      S_ROUND: st_r <= rnd_st;
      S_FINAL: begin
        acc_r  <= acc_r ^ absorbed;
        data_r <= res_m;
      end
      S_ABSORB: begin
        // A short last block is only XORed in.
        if (cnt_r == 6'd32 || !last_r) begin
          for (int j = 0; j < 8; j++) acc_r[j] <= rotl(prod[j], 11);
        end
      end
      S_TAG: acc_r <= prod ^ prod_sw;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_r  <= data_r;
          out_count_r <= cnt_r;
          out_last_r  <= last_r;
          out_tag_r   <= last_r ? tag_calc : 128'd0;
          out_match_r <= last_r && mode_r && (tag_calc == recv_tag_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_word0     = out_data_r[63:0];
  assign out_word1     = out_data_r[127:64];
  assign out_word2     = out_data_r[191:128];
  assign out_word3     = out_data_r[255:192];
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;
  assign out_tag_low   = out_tag_r[63:0];
  assign out_tag_high  = out_tag_r[127:64];
  assign out_tag_match = out_match_r;

  // The block takes no second beat in the cycle after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted back to back");

  // A tag match is only ever reported on the last beat of a message.
  a_match_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_tag_match || out_last))
    else $error("tag match outside last beat");

  // Non-last results carry an all-zero tag.
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_tag_low == 64'd0 && out_tag_high == 64'd0))
    else $error("tag present on non-last beat");

endmodule

`default_nettype wire

// ===== verif/ctr_stream_cipher_with_tag_test.sv =====
// ----------------------------------------------------------------------------
// ctr_stream_cipher_with_tag_test: self-checking bench for the tagged cipher
// Drives encrypt and decrypt messages under random flow control and compares
// every result beat, tag included, against a bit-true software model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctr_stream_cipher_with_tag_test;
  import csct_pkg::*;

  // One input beat: a 32-byte block with its control fields.
  typedef struct {
    bit             mode;
    bit [3:0][63:0] d;
    bit [5:0]       cnt;
    bit             last;
    bit [63:0]      rtag_lo;
    bit [63:0]      rtag_hi;
  } block_t;

  // One result beat.
  typedef struct {
    bit [3:0][63:0] w;
    bit [5:0]       cnt;
    bit             last;
    bit [63:0]      tag_lo;
    bit [63:0]      tag_hi;
    bit             match;
  } result_t;

  // Model of the cipher plus the queue of result beats still owed by the block.
  class cipher_scoreboard;
    bit [63:0] key[4];
    bit [63:0] iv_lo, iv_hi;
    bit [31:0] rkey[KEY_COUNT][8];
    bit [63:0] blk_num;
    bit [31:0] acc[8];
    bit        in_msg;
    result_t   owed[$];
    int        errors;

    function new();
      foreach (key[i]) key[i] = '0;
      iv_lo = '0;
      iv_hi = '0;
      blk_num = '0;
      in_msg = 0;
      errors = 0;
      expand_schedule();
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function bit [31:0] lane_of(bit [63:0] w[4], int j);
      return j[0] ? w[j/2][63:32] : w[j/2][31:0];
    endfunction

    // Round keys come from a running state mixed with the key lanes, which
    // advance by the additive constant after every round key.
    function void expand_schedule();
      bit [31:0] k[8], mixed[8], st[8];
      for (int j = 0; j < 8; j++) begin
        k[j] = lane_of(key, j);
        st[j] = EXP_INIT[j];
      end
      for (int i = 0; i < KEY_COUNT; i++) begin
        for (int j = 0; j < 8; j++) mixed[j] = st[j] * MUL_K + k[j];
        for (int j = 0; j < 8; j++) begin
          st[j] = rotl(st[j] ^ mixed[j ^ 1], 7);
          k[j] = k[j] + ADD_K;
        end
        rkey[i] = st;
      end
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] val);
      case (idx)
        REG_KEY0:    begin key[0] = val; expand_schedule(); end
        REG_KEY1:    begin key[1] = val; expand_schedule(); end
        REG_KEY2:    begin key[2] = val; expand_schedule(); end
        REG_KEY3:    begin key[3] = val; expand_schedule(); end
        REG_IV_LOW:  iv_lo = val;
        REG_IV_HIGH: iv_hi = val;
        default: ;
      endcase
    endfunction

    function void keystream(bit [63:0] n, output bit [63:0] ks[4]);
      bit [63:0] c1, c2;
      bit [31:0] st[8], t[8];
      int        src[4];
      src = '{3, 2, 0, 1};
      c1 = iv_lo + 2 * n;
      c2 = c1 + 1;
      st = '{iv_hi[63:32], iv_hi[31:0], c1[63:32], c1[31:0],
             iv_hi[63:32], iv_hi[31:0], c2[63:32], c2[31:0]};
      for (int r = 0; r < ROUND_COUNT; r++) begin
        for (int j = 0; j < 8; j++) t[j] = st[j] * MUL_K + rkey[r][j];
        // Lanes reorder as 3,2,0,1 inside each 128-bit half.
        for (int j = 0; j < 8; j++) st[j] = t[(j & 4) + src[j & 3]];
        for (int j = 0; j < 8; j++) st[j] = (st[j] ^ rotl(st[j], 13)) + ADD_K;
      end
      for (int j = 0; j < 8; j++) st[j] = st[j] ^ rkey[ROUND_COUNT][j];
      for (int i = 0; i < 4; i++) ks[i] = {st[2*i+1], st[2*i]};
    endfunction

    // Works out the result of one accepted block and queues it.
    function result_t note_block(block_t b);
      result_t   r;
      bit [63:0] ks[4], absorbed[4], mask;
      bit [31:0] t[8];
      int        cnt, nb;
      cnt = (b.cnt > 32) ? 32 : b.cnt;
      if (!in_msg) begin
        acc = '{iv_lo[31:0], iv_lo[63:32], iv_hi[31:0], iv_hi[63:32], 0, 0, 0, 0};
        blk_num = '0;
        in_msg = 1;
      end
      keystream(blk_num, ks);
      for (int i = 0; i < 4; i++) begin
        nb = (cnt > 8 * i) ? cnt - 8 * i : 0;
        mask = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 1);
        r.w[i] = (b.d[i] ^ ks[i]) & mask;
        absorbed[i] = b.mode ? (b.d[i] & mask) : r.w[i];
      end
      // A short last block is only XORed in; every other block gets the
      // multiply-add-rotate step as well.
      for (int j = 0; j < 8; j++) begin
        acc[j] = acc[j] ^ lane_of(absorbed, j);
        if (cnt == 32 || !b.last) acc[j] = rotl(acc[j] * MUL_K + ADD_K, 11);
      end
      blk_num = blk_num + 1;
      r.cnt = 6'(cnt);
      r.last = b.last;
      r.tag_lo = '0;
      r.tag_hi = '0;
      r.match = 0;
      if (b.last) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 8; j++) acc[j] = (acc[j] + rkey[i][j]) * MUL_K;
          for (int j = 0; j < 8; j++) t[j] = acc[j ^ 1];
          for (int j = 0; j < 8; j++) acc[j] = acc[j] ^ t[j];
        end
        r.tag_lo = {acc[1] ^ acc[5], acc[0] ^ acc[4]};
        r.tag_hi = {acc[3] ^ acc[7], acc[2] ^ acc[6]};
        r.match = b.mode && r.tag_lo == b.rtag_lo && r.tag_hi == b.rtag_hi;
        in_msg = 0;
      end
      owed.push_back(r);
      return r;
    endfunction

    function void cmp(string name, bit [63:0] exp, bit [63:0] act);
      if (exp !== act) begin
        $error("%s: expected %h, got %h", name, exp, act);
        errors++;
      end
    endfunction

    function void check(result_t a);
      result_t e;
      if (owed.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
        return;
      end
      e = owed.pop_front();
      for (int i = 0; i < 4; i++) cmp($sformatf("out_word%0d", i), e.w[i], a.w[i]);
      cmp("out_count", e.cnt, a.cnt);
      cmp("out_last", e.last, a.last);
      cmp("out_tag_low", e.tag_lo, a.tag_lo);
      cmp("out_tag_high", e.tag_hi, a.tag_hi);
      cmp("out_tag_match", e.match, a.match);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready;
  logic        in_mode;
  logic [63:0] in_data_word0, in_data_word1, in_data_word2, in_data_word3;
  logic [5:0]  in_byte_count;
  logic        in_last_block;
  logic [63:0] in_recv_tag_low, in_recv_tag_high;
  logic        out_valid, out_ready;
  logic [63:0] out_word0, out_word1, out_word2, out_word3;
  logic [5:0]  out_count;
  logic        out_last;
  logic [63:0] out_tag_low, out_tag_high;
  logic        out_tag_match;

  ctr_stream_cipher_with_tag dut (.*);

  cipher_scoreboard sb = new();

  // Sender burst bookkeeping, and the request for a long receiver hold-off.
  int burst_left = 0;
  int beats_sent = 0;
  bit hold_req = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous limit: the slowest correct run is far below this.
  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: the stall rate is redrawn periodically, from always ready to
  // mostly stalled, and on request it holds off for a long stretch so the
  // block backs up into its input channel.
  initial begin
    int hold_left, stall_pct, cyc;
    hold_left = 0;
    stall_pct = 0;
    cyc = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) begin
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2:    stall_pct = 30;
          3:    stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor: a beat moves at a rising edge with valid and ready high.
  always @(posedge clk) begin
    result_t a;
    if (rst_n && out_valid && out_ready) begin
      a.w = {out_word3, out_word2, out_word1, out_word0};
      a.cnt = out_count;
      a.last = out_last;
      a.tag_lo = out_tag_low;
      a.tag_hi = out_tag_high;
      a.match = out_tag_match;
      sb.check(a);
    end
  end

  // All driver tasks start and end just after a falling edge.
  task automatic write_reg(bit [2:0] idx, bit [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // The sender goes quiet, so a beat already taken is never offered again.
  task automatic wait_idle();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Offers one block, holds it until it is taken, then either keeps valid
  // high for the next beat of the burst or drops it for a random gap.
  task automatic send_block(block_t b, output result_t r);
    in_valid <= 1;
    in_mode <= b.mode;
    {in_data_word3, in_data_word2, in_data_word1, in_data_word0} <= b.d;
    in_byte_count <= b.cnt;
    in_last_block <= b.last;
    in_recv_tag_low <= b.rtag_lo;
    in_recv_tag_high <= b.rtag_hi;
    do @(posedge clk); while (!in_ready);
    r = sb.note_block(b);
    beats_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  endtask

  function automatic block_t make_block(bit mode, int cnt, bit last);
    block_t b;
    b.mode = mode;
    for (int i = 0; i < 4; i++) b.d[i] = {$urandom, $urandom};
    b.cnt = 6'(cnt);
    b.last = last;
    b.rtag_lo = {$urandom, $urandom};
    b.rtag_hi = {$urandom, $urandom};
    return b;
  endfunction

  // Encrypts a random plaintext message, then (usually) decrypts the
  // ciphertext it produced, handing over the right tag or a damaged one.
  task automatic run_pair(int nblk, int tag_ok_pct, int decrypt_pct);
    block_t  msg[$];
    result_t ct[$];
    result_t r;
    block_t  b;
    int      cnt;
    for (int i = 0; i < nblk; i++) begin
      if (i == nblk - 1) begin
        case ($urandom_range(9))
          0, 1, 2, 3: cnt = 32;
          4:          cnt = $urandom_range(33, 63);
          default:    cnt = $urandom_range(31);
        endcase
      end else begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(31) : 32;
      end
      msg.push_back(make_block(0, cnt, i == nblk - 1));
    end
    foreach (msg[i]) begin
      send_block(msg[i], r);
      ct.push_back(r);
    end
    if ($urandom_range(99) < decrypt_pct) begin
      foreach (msg[i]) begin
        b = msg[i];
        b.mode = 1;
        b.d = ct[i].w;
        b.rtag_lo = ct[nblk - 1].tag_lo;
        b.rtag_hi = ct[nblk - 1].tag_hi;
        if ($urandom_range(99) >= tag_ok_pct) begin
          if ($urandom_range(1)) b.rtag_lo[$urandom_range(63)] ^= 1'b1;
          else b.rtag_hi[$urandom_range(63)] ^= 1'b1;
        end
        send_block(b, r);
      end
    end
  endtask

  // Noise: random content, random mode per block and random tags.
  task automatic run_noise(int nblk);
    result_t r;
    for (int i = 0; i < nblk; i++)
      send_block(make_block($urandom_range(1), $urandom_range(63), i == nblk - 1), r);
  endtask

  task automatic run_traffic(int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) < 8) run_pair($urandom_range(1, 6), 75, 60);
      else run_noise($urandom_range(1, 5));
    end
  endtask

  initial begin
    block_t  b;
    result_t r;
    bit [63:0] v;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    in_mode = 0;
    {in_data_word3, in_data_word2, in_data_word1, in_data_word0} = '0;
    in_byte_count = '0;
    in_last_block = 0;
    in_recv_tag_low = '0;
    in_recv_tag_high = '0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Directed blocks under the reset key and nonce.
    b = make_block(0, 32, 1);
    b.d = '0;
    send_block(b, r);
    b.d = '1;
    send_block(b, r);
    send_block(make_block(0, 5, 1), r);           // short last block
    send_block(make_block(1, 0, 1), r);           // empty last block
    send_block(make_block(0, 63, 1), r);          // oversized counts
    send_block(make_block(1, 33, 1), r);
    send_block(make_block(0, 7, 0), r);           // short block mid-message
    send_block(make_block(0, 32, 0), r);
    send_block(make_block(0, 32, 1), r);
    send_block(make_block(0, 32, 0), r);          // mode flips mid-message
    send_block(make_block(1, 32, 0), r);
    send_block(make_block(1, 17, 1), r);
    run_pair(2, 100, 100);                        // decrypt, good tag
    run_pair(1, 0, 100);                          // decrypt, damaged tag

    // Phases with fresh register settings, extremes first. The counter
    // base sits just below the wrap point in the first one.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      for (int i = 0; i < 6; i++) begin
        case (p)
          0: v = (i == int'(REG_IV_LOW)) ? 64'hFFFF_FFFF_FFFF_FFFD : '1;
          1: v = (i == int'(REG_IV_HIGH)) ? {$urandom, $urandom} : '0;
          default: v = {$urandom, $urandom};
        endcase
        write_reg(i[2:0], v);
      end
      if (p == 2) hold_req = 1;
      if (p == 3) begin
        run_traffic(90);
        wait_idle();                              // sender waits out the block
        run_traffic(90);
      end else begin
        run_traffic(185);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
